/* hw/rtl/single_source_shortest_path_defines.svh */
// Assertion helpers shared by the shortest path block.
// Both forms are clocked on clk and are disabled while arst_n is low.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and constants shared by the shortest path controller and datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int VTX_N       = 64;
	localparam int VW          = 6;
	localparam int CNT_W       = 7;
	localparam int DIST_W      = 22;
	localparam int WEIGHT_BITS = 16;

	localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
	localparam logic [CNT_W-1:0]  VTX_N_CNT   = CNT_W'(VTX_N);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_SOLVE = 2'd2
	} cmd_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SCAN_END,
		ST_EDGE_RD,
		ST_EDGE_CHK,
		ST_EDGE_UPD,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	typedef struct packed {
		logic [VW-1:0]          tail;
		logic [VW-1:0]          head;
		logic [WEIGHT_BITS-1:0] len;
	} edge_rec_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic init;
		logic scan_clr;
		logic scan_cmp;
		logic finish;
		logic edge_clr;
		logic edge_step;
		logic rd_head;
		logic relax;
		logic idx_clr;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic found;
		logic idx_last;
		logic edges_empty;
		logic edge_match;
		logic edge_last;
		logic out_free;
	} dp_status_t;

endpackage

/* hw/rtl/ssp_ctrl.sv */
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer for edge loading, the Dijkstra scan and relax passes, and output.
// ----------------------------------------------------------------------------
module ssp_ctrl import ssp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (command)
						CMD_CLEAR: cmd.clear = 1'b1;
						CMD_ADD:   cmd.add   = 1'b1;
						CMD_SOLVE: begin
							cmd.init     = 1'b1;
							cmd.scan_clr = 1'b1;
							state_d      = ST_SCAN_RD;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = status.idx_last ? ST_SCAN_END : ST_SCAN_RD;
			end
			ST_SCAN_END: begin
				if (!status.found) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_OUT_RD;
				end else begin
					cmd.finish   = 1'b1;
					cmd.edge_clr = 1'b1;
					if (status.edges_empty) begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN_RD;
					end else begin
						state_d = ST_EDGE_RD;
					end
				end
			end
			ST_EDGE_RD: state_d = ST_EDGE_CHK;
			ST_EDGE_CHK: begin
				cmd.rd_head = 1'b1;
				if (status.edge_match) begin
					state_d = ST_EDGE_UPD;
				end else begin
					cmd.edge_step = 1'b1;
					cmd.scan_clr  = status.edge_last;
					state_d       = status.edge_last ? ST_SCAN_RD : ST_EDGE_RD;
				end
			end
			ST_EDGE_UPD: begin
				cmd.relax     = 1'b1;
				cmd.edge_step = 1'b1;
				cmd.scan_clr  = status.edge_last;
				state_d       = status.edge_last ? ST_SCAN_RD : ST_EDGE_RD;
			end
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = status.idx_last ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/ssp_dp.sv */
// ----------------------------------------------------------------------------
// ssp_dp
// Edge store, distance memory, scan and relax arithmetic, and result register.
// ----------------------------------------------------------------------------
`include "single_source_shortest_path_defines.svh"

module ssp_dp import ssp_pkg::*; #(
	parameter int MAX_EDGES = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	input  logic [CNT_W-1:0]       vertex_count,
	input  logic [VW-1:0]          edge_from,
	input  logic [VW-1:0]          edge_to,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic [VW-1:0]          source_vertex,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [VW-1:0]          vertex,
	output logic [DIST_W-1:0]      distance,
	output logic                   reachable,
	output logic                   edge_overflow,
	output logic                   last
);

	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam logic [CW-1:0] EDGES_FULL = CW'(MAX_EDGES);

	edge_rec_t            edge_mem [MAX_EDGES];
	logic [DIST_W-1:0]    dist_mem [VTX_N];

	logic [CW-1:0]        edges_held_q;
	logic                 overflow_q;
	logic [VTX_N-1:0]     known_q;
	logic [VTX_N-1:0]     fin_q;
	logic [CNT_W-1:0]     n_q;
	logic [VW-1:0]        idx_q;
	logic [EW-1:0]        e_q;
	logic                 found_q;
	logic [VW-1:0]        u_q;
	logic [DIST_W-1:0]    bestd_q;
	edge_rec_t            ed_q;
	logic [DIST_W-1:0]    drd_q;

	logic                 full;
	logic [CNT_W-1:0]     n_in;
	logic                 src_ok;
	logic [VW-1:0]        rd_addr;
	logic                 cand;
	logic [DIST_W:0]      alt;
	logic [DIST_W-1:0]    alt_sat;
	logic                 better;
	logic                 dist_we;
	logic [VW-1:0]        dist_wa;
	logic [DIST_W-1:0]    dist_wd;
	logic                 out_valid_q;

	assign full   = (edges_held_q == EDGES_FULL);
	assign n_in   = (vertex_count == '0) ? CNT_W'(1) :
	                (vertex_count > VTX_N_CNT) ? VTX_N_CNT : vertex_count;
	assign src_ok = ({1'b0, source_vertex} < n_in);

	assign rd_addr = cmd.rd_head ? ed_q.head : idx_q;
	assign cand    = known_q[idx_q] && !fin_q[idx_q] && (!found_q || drd_q < bestd_q);
	assign alt     = {1'b0, bestd_q} + (DIST_W + 1)'(ed_q.len);
	assign alt_sat = alt[DIST_W] ? DIST_MAX : alt[DIST_W-1:0];
	assign better  = !known_q[ed_q.head] || (alt < {1'b0, drd_q});

	assign dist_we = (cmd.init && src_ok) || (cmd.relax && better);
	assign dist_wa = cmd.init ? source_vertex : ed_q.head;
	assign dist_wd = cmd.init ? '0 : alt_sat;

	assign status.found       = found_q;
	assign status.idx_last    = (({1'b0, idx_q} + CNT_W'(1)) == n_q);
	assign status.edges_empty = (edges_held_q == '0);
	assign status.edge_match  = (ed_q.tail == u_q) && ({1'b0, ed_q.head} < n_q);
	assign status.edge_last   = ((CW'(e_q) + CW'(1)) == edges_held_q);
	assign status.out_free    = !out_valid_q || out_ready;

	// Memories: one write and one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.add && !full) begin
			edge_mem[edges_held_q[EW-1:0]] <= '{tail: edge_from, head: edge_to,
			                                    len: edge_weight};
		end
		ed_q <= edge_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		drd_q <= dist_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_held_q <= '0;
			overflow_q   <= 1'b0;
			known_q      <= '0;
			fin_q        <= '0;
			n_q          <= VTX_N_CNT;
			idx_q        <= '0;
			e_q          <= '0;
			found_q      <= 1'b0;
			u_q          <= '0;
			bestd_q      <= '0;
		end else begin
			if (cmd.clear) begin
				edges_held_q <= '0;
				overflow_q   <= 1'b0;
			end else if (cmd.add) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					edges_held_q <= edges_held_q + CW'(1);
				end
			end
			if (cmd.init) begin
				n_q     <= n_in;
				fin_q   <= '0;
				known_q <= '0;
				if (src_ok) begin
					known_q[source_vertex] <= 1'b1;
				end
			end else if (cmd.relax && better) begin
				known_q[ed_q.head] <= 1'b1;
			end
			if (cmd.finish) begin
				fin_q[u_q] <= 1'b1;
			end
			if (cmd.scan_clr || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_cmp || cmd.out_load) begin
				idx_q <= idx_q + VW'(1);
			end
			if (cmd.scan_clr) begin
				found_q <= 1'b0;
			end else if (cmd.scan_cmp && cand) begin
				found_q <= 1'b1;
				u_q     <= idx_q;
				bestd_q <= drd_q;
			end
			if (cmd.edge_clr) begin
				e_q <= '0;
			end else if (cmd.edge_step) begin
				e_q <= e_q + EW'(1);
			end
		end
	end

	// Result register: holds one result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			vertex        <= idx_q;
			distance      <= known_q[idx_q] ? drd_q : '0;
			reachable     <= known_q[idx_q];
			edge_overflow <= overflow_q;
			last          <= status.idx_last;
		end
	end

	assign out_valid = out_valid_q;

	`SSP_ASSERT_NEXT(a_clear_empties, cmd.clear, (edges_held_q == '0) && !overflow_q, "clear did not empty the edge store")
	`SSP_ASSERT_NEXT(a_full_sets_ovf, cmd.add && full, overflow_q, "dropped edge did not set overflow")
	`SSP_ASSERT_NOW(a_finish_known, cmd.finish, known_q[u_q] && found_q, "finished vertex has no known distance")
	`SSP_ASSERT_NEXT(a_src_known, cmd.init && src_ok, known_q[$past(source_vertex)], "source not marked known")

endmodule

/* hw/rtl/single_source_shortest_path.sv */
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Dijkstra shortest paths over a stored directed graph, results per vertex.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Carries
// input     in_valid / in_ready    command, edge_from, edge_to, edge_weight,
//                                  source_vertex
// output    out_valid / out_ready  vertex, distance, reachable, edge_overflow,
//                                  last
// config    APB (psel, penable)    vertex_count at byte address 0
//
// Clear and add-edge transfers are taken one per cycle. A solve holds in_ready
// low until its last result has been loaded into the output register: each
// pass picks a vertex by stepping through the distance memory with a read
// state and a compare state per vertex, and relaxes through the edge store
// with a read state and a check state per edge, plus an update state for an
// edge leaving the picked vertex. Reset clears the edge count, the overflow
// flag and all status bits; the memories themselves are not cleared. A
// stalled output only holds the sequencer in its output step.
//
// The solve sequence is a state machine in ssp_ctrl; the memories, counters
// and the compare and add logic live in ssp_dp. The distance memory entry of
// a vertex is only read where its known bit is set, so it needs no clearing.
module single_source_shortest_path import ssp_pkg::*; #(
	parameter int MAX_EDGES = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// Input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [VW-1:0]          edge_from,
	input  logic [VW-1:0]          edge_to,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic [VW-1:0]          source_vertex,
	// Output channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VW-1:0]          vertex,
	output logic [DIST_W-1:0]      distance,
	output logic                   reachable,
	output logic                   edge_overflow,
	output logic                   last
);

	logic [CNT_W-1:0] vertex_count_q;
	ctrl_cmd_t        cmd;
	dp_status_t       status;

	// The only register sits at byte address 0; writes with paddr[2] set are ignored.
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, vertex_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VTX_N_CNT;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			vertex_count_q <= pwdata[CNT_W-1:0];
		end
	end

	ssp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.status   (status),
		.cmd      (cmd)
	);

	ssp_dp #(
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.vertex_count  (vertex_count_q),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.edge_weight   (edge_weight),
		.source_vertex (source_vertex),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.vertex        (vertex),
		.distance      (distance),
		.reachable     (reachable),
		.edge_overflow (edge_overflow),
		.last          (last)
	);

endmodule
